/* rtl/kpc_pkg.sv */
// Shared types, phase and event codes for the key press classifier.
package kpc_pkg;

  localparam int unsigned NumKeys   = 7;
  localparam int unsigned KeyIdxW   = 3;
  localparam int unsigned StampW    = 32;
  localparam int unsigned MsRegW    = 16;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned EventW    = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 8;

  // Phase codes
  localparam logic [PhaseW-1:0] PhIdle    = 3'd0;
  localparam logic [PhaseW-1:0] PhPress   = 3'd1;
  localparam logic [PhaseW-1:0] PhJudge   = 3'd2;
  localparam logic [PhaseW-1:0] PhMisfire = 3'd3;
  localparam logic [PhaseW-1:0] PhShort   = 3'd4;
  localparam logic [PhaseW-1:0] PhDouble  = 3'd5;
  localparam logic [PhaseW-1:0] PhLong    = 3'd6;

  // Event codes
  localparam logic [EventW-1:0] EvNone    = 3'd0;
  localparam logic [EventW-1:0] EvMisfire = 3'd1;
  localparam logic [EventW-1:0] EvShort   = 3'd2;
  localparam logic [EventW-1:0] EvDouble  = 3'd3;
  localparam logic [EventW-1:0] EvLong    = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLongPress   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDoubleGap   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgReleaseHold = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMinPress    = 2'd3;

  // Reset values of the configuration registers
  localparam logic [MsRegW-1:0] LongPressRst   = 16'd3000;
  localparam logic [MsRegW-1:0] DoubleGapRst   = 16'd300;
  localparam logic [MsRegW-1:0] ReleaseHoldRst = 16'd100;
  localparam logic [MsRegW-1:0] MinPressRst    = 16'd100;

  typedef struct packed {
    logic [MsRegW-1:0] long_press_ms;
    logic [MsRegW-1:0] double_gap_ms;
    logic [MsRegW-1:0] release_hold_ms;
    logic [MsRegW-1:0] min_press_ms;
  } kpc_cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [KeyIdxW-1:0] tracked_key;
    logic [StampW-1:0]  press_stamp;
    logic [StampW-1:0]  release_stamp;
    logic [StampW-1:0]  event_stamp;
    logic               reported;
  } kpc_state_t;

  typedef struct packed {
    logic               valid_click;
    logic               idle_flag;
    logic [KeyIdxW-1:0] key_index;
    logic [EventW-1:0]  event_code;
  } kpc_result_t;

endpackage

/* rtl/kpc_step.sv */
// Next-state and result logic for one scan tick of the key press classifier.
module kpc_step (
  input  kpc_pkg::kpc_cfg_t             cfg_i,
  input  kpc_pkg::kpc_state_t           state_i,
  input  logic [kpc_pkg::NumKeys-1:0]   keys_i,
  input  logic [kpc_pkg::StampW-1:0]    now_i,
  output kpc_pkg::kpc_state_t           state_o,
  output kpc_pkg::kpc_result_t          result_o
);

  logic [7:0]                    keys_ext;
  logic                          down;
  logic                          found;
  logic                          done;
  logic [kpc_pkg::EventW-1:0]    ev;
  logic [kpc_pkg::StampW-1:0]    held_ms;
  logic [kpc_pkg::StampW-1:0]    gap_ms;
  logic [kpc_pkg::StampW-1:0]    press_len_ms;
  logic [kpc_pkg::StampW-1:0]    since_event_ms;
  logic [kpc_pkg::StampW-1:0]    long_lim;
  logic [kpc_pkg::StampW-1:0]    gap_lim;
  logic [kpc_pkg::StampW-1:0]    hold_lim;
  logic [kpc_pkg::StampW-1:0]    min_lim;
  kpc_pkg::kpc_state_t           nxt;

  assign keys_ext = {{(8 - kpc_pkg::NumKeys){1'b0}}, keys_i};
  assign down     = keys_ext[state_i.tracked_key];

  assign long_lim = {{(kpc_pkg::StampW - kpc_pkg::MsRegW){1'b0}}, cfg_i.long_press_ms};
  assign gap_lim  = {{(kpc_pkg::StampW - kpc_pkg::MsRegW){1'b0}}, cfg_i.double_gap_ms};
  assign hold_lim = {{(kpc_pkg::StampW - kpc_pkg::MsRegW){1'b0}}, cfg_i.release_hold_ms};
  assign min_lim  = {{(kpc_pkg::StampW - kpc_pkg::MsRegW){1'b0}}, cfg_i.min_press_ms};

  assign held_ms      = now_i - state_i.press_stamp;
  assign gap_ms       = now_i - state_i.release_stamp;
  assign press_len_ms = state_i.release_stamp - state_i.press_stamp;

  always_comb begin
    nxt   = state_i;
    ev    = kpc_pkg::EvNone;
    done  = 1'b0;
    found = 1'b0;

    unique case (state_i.phase)
      kpc_pkg::PhIdle: begin
        // capture the lowest pressed key
        for (int i = 0; i < kpc_pkg::NumKeys; i++) begin
          if (keys_i[i] && !found) begin
            found           = 1'b1;
            nxt.tracked_key = kpc_pkg::KeyIdxW'(i);
            nxt.press_stamp = now_i;
            nxt.phase       = kpc_pkg::PhPress;
          end
        end
      end
      kpc_pkg::PhPress: begin
        if (held_ms > long_lim) begin
          nxt.event_stamp = now_i;
          nxt.reported    = 1'b0;
          nxt.phase       = kpc_pkg::PhLong;
        end else if (!down) begin
          nxt.release_stamp = now_i;
          nxt.phase         = kpc_pkg::PhJudge;
        end
      end
      kpc_pkg::PhJudge: begin
        if (down && (gap_ms < gap_lim)) begin
          nxt.event_stamp = now_i;
          nxt.reported    = 1'b0;
          nxt.phase       = kpc_pkg::PhDouble;
        end else if (gap_ms > gap_lim) begin
          nxt.event_stamp = now_i;
          nxt.reported    = 1'b0;
          nxt.phase       = (press_len_ms >= min_lim) ? kpc_pkg::PhShort
                                                      : kpc_pkg::PhMisfire;
        end
      end
      kpc_pkg::PhMisfire: begin
        ev   = kpc_pkg::EvMisfire;
        done = 1'b1;
      end
      kpc_pkg::PhShort: begin
        ev   = kpc_pkg::EvShort;
        done = 1'b1;
      end
      kpc_pkg::PhDouble: begin
        if (!state_i.reported) begin
          ev           = kpc_pkg::EvDouble;
          nxt.reported = 1'b1;
        end
      end
      kpc_pkg::PhLong: begin
        if (!state_i.reported) begin
          ev           = kpc_pkg::EvLong;
          nxt.reported = 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase

    // hold a long or double state until the hold time is over and the key is up
    if ((nxt.phase == kpc_pkg::PhLong || nxt.phase == kpc_pkg::PhDouble) &&
        (since_event_ms > hold_lim) && !down) begin
      done = 1'b1;
    end

    result_o.event_code = ev;
    result_o.key_index  = nxt.tracked_key;

    if (done) begin
      nxt.phase       = kpc_pkg::PhIdle;
      nxt.tracked_key = '0;
      nxt.reported    = 1'b0;
    end

    result_o.idle_flag   = (nxt.phase == kpc_pkg::PhIdle);
    result_o.valid_click = (nxt.phase == kpc_pkg::PhShort) ||
                           (nxt.phase == kpc_pkg::PhDouble) ||
                           (nxt.phase == kpc_pkg::PhLong);
    state_o = nxt;
  end

  // event stamp as it stands after this tick's transition
  always_comb begin
    logic [kpc_pkg::StampW-1:0] stamp;
    stamp = state_i.event_stamp;
    if ((state_i.phase == kpc_pkg::PhPress && held_ms > long_lim) ||
        (state_i.phase == kpc_pkg::PhJudge &&
         ((down && gap_ms < gap_lim) || gap_ms > gap_lim))) begin
      stamp = now_i;
    end
    since_event_ms = now_i - stamp;
  end

endmodule

/* rtl/key_press_classifier.sv */
// Top level of the key press classifier: handshakes, registers and state.
//
// Classifies presses of a bank of seven keys into misfire, short, double and
// long events. Each input transaction is one scan tick: the pressed bits of
// the keys and a wrapping millisecond timestamp. Every input transaction
// yields exactly one output transaction carrying the event code (non-zero
// only on the tick that reports it), the tracked key, an idle flag and a
// click flag. The block takes one transaction per clock cycle while the
// output is not stalled; a result passes through the input register and then
// the result register that bracket the single pass of decision logic.
// Back-pressure on the output stalls the input register, which in turn drops
// s_axis_tready. The four 16-bit timing registers are written through the
// configuration channel, which is always ready; write them only while no
// tick is in flight.
module key_press_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kpc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [kpc_pkg::MsRegW-1:0]      cfg_data_i,
  // scan tick input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [6:0] keys_pressed, [38:7] now_ms, [39] zero
  input  logic [kpc_pkg::InDataW-1:0]     s_axis_tdata,
  // classification result
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] event_code, [5:3] key_index, [6] idle_flag, [7] valid_click
  output logic [kpc_pkg::OutDataW-1:0]    m_axis_tdata
);

  kpc_pkg::kpc_cfg_t               cfg_q;
  kpc_pkg::kpc_state_t             state_q;
  kpc_pkg::kpc_state_t             state_d;
  kpc_pkg::kpc_result_t            result_d;

  logic                            in_valid_q;
  logic [kpc_pkg::NumKeys-1:0]     in_keys_q;
  logic [kpc_pkg::StampW-1:0]      in_now_q;

  logic                            out_valid_q;
  kpc_pkg::kpc_result_t            out_q;

  logic                            advance;
  logic                            in_take;

  // The configuration channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms   <= kpc_pkg::LongPressRst;
      cfg_q.double_gap_ms   <= kpc_pkg::DoubleGapRst;
      cfg_q.release_hold_ms <= kpc_pkg::ReleaseHoldRst;
      cfg_q.min_press_ms    <= kpc_pkg::MinPressRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kpc_pkg::CfgLongPress:   cfg_q.long_press_ms   <= cfg_data_i;
        kpc_pkg::CfgDoubleGap:   cfg_q.double_gap_ms   <= cfg_data_i;
        kpc_pkg::CfgReleaseHold: cfg_q.release_hold_ms <= cfg_data_i;
        kpc_pkg::CfgMinPress:    cfg_q.min_press_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the held tick into the result register when that register is
  // free or being emptied in this cycle; the state moves with it.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register: hold the tick until it is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_keys_q <= s_axis_tdata[kpc_pkg::NumKeys-1:0];
      in_now_q  <= s_axis_tdata[kpc_pkg::NumKeys +: kpc_pkg::StampW];
    end
  end

  kpc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .keys_i   (in_keys_q),
    .now_i    (in_now_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Classifier state: update once per processed tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= kpc_pkg::PhIdle;
      state_q.tracked_key   <= '0;
      state_q.press_stamp   <= '0;
      state_q.release_stamp <= '0;
      state_q.event_stamp   <= '0;
      state_q.reported      <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

/* verif/tb_key_press_classifier.sv */
// Testbench for key_press_classifier: directed and random scan ticks checked against a tick model.
module tb_key_press_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned ResetCycles = 7;
  // Idle cycles after the last result, for the input and result registers to empty.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 1_000_000;

  // Clock, reset and every input of the block, known from time zero
  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [kpc_pkg::CfgIdxW-1:0]  cfg_index_i   = kpc_pkg::CfgLongPress;
  logic [kpc_pkg::MsRegW-1:0]   cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // [6:0] keys_pressed, [38:7] now_ms, [39] zero
  logic [kpc_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // [2:0] event_code, [5:3] key_index, [6] idle_flag, [7] valid_click
  logic [kpc_pkg::OutDataW-1:0] m_axis_tdata;

  // Tick model: timing registers and classifier state, as the block should hold them
  kpc_pkg::kpc_cfg_t    timing;
  kpc_pkg::kpc_state_t  tracker;
  kpc_pkg::kpc_result_t expected_results [$];

  logic [31:0] clock_ms;        // timestamp of the most recent scan tick
  int unsigned ticks_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_calm     = 0; // remaining input transactions sent without gaps
  int unsigned rx_calm     = 0; // remaining output cycles without stalls
  int unsigned stall_left  = 0;

  key_press_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Length of the next idle stretch: mostly none or short, now and then long,
  // and from time to time a calm run with no idling at all.
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A duration close to a threshold (to land on its edges) or anywhere up to twice it.
  function automatic logic [31:0] around_ms(input logic [15:0] base);
    int v;
    if ($urandom_range(0, 9) < 7) begin
      v = int'(base) + int'($urandom_range(0, 4)) - 2;
      return (v < 0) ? 32'd0 : 32'(v);
    end
    return $urandom_range(0, 2 * int'(base) + 4);
  endfunction

  // Advance the tick model by one scan tick and return the result it must produce.
  function automatic kpc_pkg::kpc_result_t classify_tick(input logic [6:0] keys,
                                                         input logic [31:0] now);
    kpc_pkg::kpc_result_t        res;
    logic [kpc_pkg::EventW-1:0]  ev;
    logic [kpc_pkg::KeyIdxW-1:0] key_seen;
    logic [31:0]                 gap;
    logic                        held, finished, found;
    ev       = kpc_pkg::EvNone;
    finished = 1'b0;
    found    = 1'b0;
    // Only the tracked key counts once a press is under way
    held = (32'(tracker.tracked_key) < kpc_pkg::NumKeys) ? keys[tracker.tracked_key] : 1'b0;
    gap  = 32'(now - tracker.release_stamp);
    case (tracker.phase)
      kpc_pkg::PhIdle: begin
        // Capture the lowest pressed key
        for (int i = 0; i < kpc_pkg::NumKeys; i++) begin
          if (!found && keys[i]) begin
            found               = 1'b1;
            tracker.tracked_key = kpc_pkg::KeyIdxW'(i);
            tracker.press_stamp = now;
            tracker.phase       = kpc_pkg::PhPress;
          end
        end
      end
      kpc_pkg::PhPress: begin
        if (32'(now - tracker.press_stamp) > 32'(timing.long_press_ms)) begin
          tracker.event_stamp = now;
          tracker.reported    = 1'b0;
          tracker.phase       = kpc_pkg::PhLong;
        end else if (!held) begin
          tracker.release_stamp = now;
          tracker.phase         = kpc_pkg::PhJudge;
        end
      end
      kpc_pkg::PhJudge: begin
        // A gap exactly equal to the window neither doubles nor closes it
        if (held && gap < 32'(timing.double_gap_ms)) begin
          tracker.event_stamp = now;
          tracker.reported    = 1'b0;
          tracker.phase       = kpc_pkg::PhDouble;
        end else if (gap > 32'(timing.double_gap_ms)) begin
          tracker.event_stamp = now;
          tracker.reported    = 1'b0;
          tracker.phase = (32'(tracker.release_stamp - tracker.press_stamp) >=
                           32'(timing.min_press_ms)) ? kpc_pkg::PhShort
                                                     : kpc_pkg::PhMisfire;
        end
      end
      kpc_pkg::PhMisfire: begin
        ev       = kpc_pkg::EvMisfire;
        finished = 1'b1;
      end
      kpc_pkg::PhShort: begin
        ev       = kpc_pkg::EvShort;
        finished = 1'b1;
      end
      kpc_pkg::PhDouble, kpc_pkg::PhLong: begin
        // Report once, on the first tick after entry
        if (!tracker.reported) begin
          ev               = (tracker.phase == kpc_pkg::PhDouble) ? kpc_pkg::EvDouble
                                                                  : kpc_pkg::EvLong;
          tracker.reported = 1'b1;
        end
      end
      default: finished = 1'b1;
    endcase
    // Leave a long or double state only after the hold time with the key up
    if ((tracker.phase == kpc_pkg::PhLong || tracker.phase == kpc_pkg::PhDouble) &&
        32'(now - tracker.event_stamp) > 32'(timing.release_hold_ms) && !held)
      finished = 1'b1;
    key_seen = tracker.tracked_key;
    if (finished) begin
      tracker.phase       = kpc_pkg::PhIdle;
      tracker.tracked_key = '0;
      tracker.reported    = 1'b0;
    end
    res.event_code  = ev;
    res.key_index   = key_seen;
    res.idle_flag   = (tracker.phase == kpc_pkg::PhIdle);
    res.valid_click = (tracker.phase == kpc_pkg::PhShort ||
                       tracker.phase == kpc_pkg::PhDouble ||
                       tracker.phase == kpc_pkg::PhLong);
    return res;
  endfunction

  // Send one scan tick, after a random gap, and hold it until the block takes it.
  // Valid stays high afterwards so that back-to-back ticks need no idle gap between them.
  task automatic send_tick(input logic [6:0] keys, input logic [31:0] now);
    int unsigned gap;
    gap = idle_len(tx_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, now, keys};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(classify_tick(keys, now));
    ticks_sent++;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all four timing registers while the block is idle.
  task automatic load_timing(input logic [15:0] long_ms, input logic [15:0] gap_ms,
                             input logic [15:0] hold_ms, input logic [15:0] min_ms);
    logic [kpc_pkg::CfgIdxW-1:0] regs [4];
    logic [kpc_pkg::MsRegW-1:0]  vals [4];
    settle();
    regs = '{kpc_pkg::CfgLongPress, kpc_pkg::CfgDoubleGap, kpc_pkg::CfgReleaseHold,
             kpc_pkg::CfgMinPress};
    vals = '{long_ms, gap_ms, hold_ms, min_ms};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (regs[i])
        kpc_pkg::CfgLongPress:   timing.long_press_ms   = vals[i];
        kpc_pkg::CfgDoubleGap:   timing.double_gap_ms   = vals[i];
        kpc_pkg::CfgReleaseHold: timing.release_hold_ms = vals[i];
        default:                 timing.min_press_ms    = vals[i];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Short press of exactly the minimum length; the judge window is hit on its
  // exact edge with the key up, so the block waits one more tick.
  task automatic test_short_at_window_edge();
    send_tick(7'b0000000, 32'd1000);
    send_tick(7'b0110100, 32'd1001);  // keys 2, 4 and 5: capture key 2
    send_tick(7'b0000100, 32'd1050);
    send_tick(7'b0010000, 32'd1101);  // key 2 up after exactly the minimum
    send_tick(7'b0000000, 32'd1401);  // gap equals the window: keep waiting
    send_tick(7'b0000000, 32'd1402);  // window closed: short
    send_tick(7'b0000000, 32'd1403);  // report short, back to idle
  endtask

  // Misfire after a second press exactly on the window edge, then a double press.
  task automatic test_misfire_and_double();
    send_tick(7'b1000000, 32'd2000);  // highest key alone
    send_tick(7'b0000000, 32'd2099);  // released one short of the minimum
    send_tick(7'b1000000, 32'd2399);  // pressed again exactly at the window edge
    send_tick(7'b0000000, 32'd2400);  // window closed: misfire
    send_tick(7'b0000000, 32'd2401);
    send_tick(7'b0000001, 32'd3000);
    send_tick(7'b0000000, 32'd3200);
    send_tick(7'b1111111, 32'd3499);  // second press just inside the window
    send_tick(7'b0000001, 32'd3500);  // report double
    send_tick(7'b0000000, 32'd3600);  // hold passed and key up: idle
  endtask

  // Long press whose duration is measured across the timestamp wrap.
  task automatic test_long_across_wrap();
    logic [31:0] base;
    base = 32'hFFFF_FF00;
    send_tick(7'b0001000, base);
    send_tick(7'b0001000, base + 32'd3000);  // exactly the limit: still a press
    send_tick(7'b0001000, base + 32'd3001);  // beyond it: long
    send_tick(7'b0001000, base + 32'd3050);  // report long
    send_tick(7'b0001000, base + 32'd3200);  // hold passed but key still down
    send_tick(7'b1110111, base + 32'd3201);  // tracked key up: idle
  endtask

  // One well-formed press of a random key with random content around the thresholds.
  task automatic press_gesture();
    logic [kpc_pkg::KeyIdxW-1:0] k;
    logic [6:0]                  bit_k, above;
    logic [31:0]                 t_press, t_rel, hold_ms;
    logic [15:0]                 span;
    int unsigned                 steps, tries;
    k       = kpc_pkg::KeyIdxW'($urandom_range(0, kpc_pkg::NumKeys - 1));
    bit_k   = 7'd1 << k;
    above   = 7'($urandom) & (7'h7F << (k + 1));
    clock_ms = clock_ms + $urandom_range(1, 8);
    t_press  = clock_ms;
    send_tick(bit_k | above, clock_ms);
    case ($urandom_range(0, 3))
      0:       hold_ms = around_ms(timing.min_press_ms);
      1:       hold_ms = around_ms(timing.long_press_ms);
      2:       hold_ms = $urandom_range(0, int'(timing.long_press_ms) + 8);
      default: hold_ms = $urandom_range(0, 2 * int'(timing.min_press_ms) + 8);
    endcase
    steps = $urandom_range(0, 2);
    for (int i = 1; i <= steps; i++) begin
      clock_ms = t_press + hold_ms * i / (steps + 1);
      send_tick(bit_k | 7'($urandom), clock_ms);
    end
    // Release the tracked key; other keys may do as they like
    clock_ms = t_press + hold_ms;
    send_tick(7'($urandom) & ~bit_k, clock_ms);
    t_rel    = clock_ms;
    clock_ms = t_rel + around_ms(timing.double_gap_ms);
    if ($urandom_range(0, 1)) begin
      // Second press near the window edge, then held or let go near the hold edge
      send_tick(bit_k | 7'($urandom), clock_ms);
      clock_ms = clock_ms + around_ms(timing.release_hold_ms);
      send_tick(($urandom_range(0, 1) ? bit_k : 7'd0) | (7'($urandom) & ~bit_k), clock_ms);
    end else begin
      send_tick(7'($urandom) & ~bit_k, clock_ms);
    end
    // Run the gesture out with the tracked key up until the block is idle again, trying at most eight times
    span  = (timing.double_gap_ms > timing.release_hold_ms) ?
            timing.double_gap_ms : timing.release_hold_ms;
    tries = 0;
    while (tracker.phase != kpc_pkg::PhIdle && tries < 8) begin
      clock_ms = clock_ms + around_ms(span) + 32'd1;
      send_tick(7'($urandom) & ~(7'd1 << tracker.tracked_key), clock_ms);
      tries++;
    end
  endtask

  // A few ticks of random keys and jumping timestamps.
  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        clock_ms = $urandom;
      else
        clock_ms = clock_ms + $urandom_range(0, 2 * int'(timing.long_press_ms) + 16);
      send_tick(7'($urandom), clock_ms);
    end
  endtask

  // Mostly well-formed presses, the rest noise, under one timing setting.
  task automatic test_random_presses(input logic [15:0] long_ms, input logic [15:0] gap_ms,
                                     input logic [15:0] hold_ms, input logic [15:0] min_ms,
                                     input int unsigned count);
    int unsigned goal;
    load_timing(long_ms, gap_ms, hold_ms, min_ms);
    clock_ms = $urandom;
    goal     = ticks_sent + count;
    while (ticks_sent < goal) begin
      if ($urandom_range(0, 99) < 85)
        press_gesture();
      else
        noise_burst();
    end
  endtask

  // Output back-pressure: random stalls with calm stretches in between.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left    <= idle_len(rx_calm);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare every output transaction with the oldest expectation, field by field.
  always @(posedge clk_i) begin : result_check
    kpc_pkg::kpc_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("event_code", 32'(want.event_code), 32'(got.event_code));
        check_field("key_index", 32'(want.key_index), 32'(got.key_index));
        check_field("idle_flag", 32'(want.idle_flag), 32'(got.idle_flag));
        check_field("valid_click", 32'(want.valid_click), 32'(got.valid_click));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_key_press_classifier: done, errors");
      $finish;
    end
  end

  initial begin
    timing  = '{long_press_ms: kpc_pkg::LongPressRst, double_gap_ms: kpc_pkg::DoubleGapRst,
                release_hold_ms: kpc_pkg::ReleaseHoldRst, min_press_ms: kpc_pkg::MinPressRst};
    tracker = '0;
    clock_ms = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks run on the reset values of the timing registers
    test_short_at_window_edge();
    test_misfire_and_double();
    test_long_across_wrap();

    // Random traffic under several settings, the extremes among them
    test_random_presses(16'd40, 16'd12, 16'd6, 16'd10, 450);
    test_random_presses(16'd0, 16'd0, 16'd0, 16'd0, 150);
    test_random_presses(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 200);
    test_random_presses(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                        16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 350);
    test_random_presses(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 250);
    test_random_presses(kpc_pkg::LongPressRst, kpc_pkg::DoubleGapRst,
                        kpc_pkg::ReleaseHoldRst, kpc_pkg::MinPressRst, 300);

    settle();
    if (mismatches == 0) begin
      $display("tb_key_press_classifier: done, clean");
    end else begin
      $display("tb_key_press_classifier: done, errors");
    end
    $finish;
  end

endmodule
